// ----- rtl/glbp_pkg.sv -----
// ---------------------------------------------------------------------------
// glbp_pkg: shared types and constants for the greedy label box placer
// Request and status codes, store sizing, sequencer states.
// ---------------------------------------------------------------------------
package glbp_pkg;

    localparam int MAX_BOXES = 256;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = IDX_W + 1;
    // internal coordinate width: inputs are at most 16 bits signed, 20 bits is ample
    localparam int CW        = 20;

    localparam logic [1:0] REQ_RESERVE = 2'd0;
    localparam logic [1:0] REQ_PLACE   = 2'd1;

    localparam logic [2:0] ST_PLACED  = 3'd0;
    localparam logic [2:0] ST_NOPOS   = 3'd1;
    localparam logic [2:0] ST_LIMIT   = 3'd2;
    localparam logic [2:0] ST_RESERVE = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    localparam logic [2:0] CFG_IMG_W   = 3'd0;
    localparam logic [2:0] CFG_IMG_H   = 3'd1;
    localparam logic [2:0] CFG_FONT    = 3'd2;
    localparam logic [2:0] CFG_RADIUS  = 3'd3;
    localparam logic [2:0] CFG_OUTLINE = 3'd4;
    localparam logic [2:0] CFG_PAD     = 3'd5;
    localparam logic [2:0] CFG_AVOID   = 3'd6;
    localparam logic [2:0] CFG_MAXLAB  = 3'd7;

    localparam logic [2:0] NUM_POS = 3'd6;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord l;
        t_coord t;
        t_coord r;
        t_coord b;
    } t_rect;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CAND,
        S_READ,
        S_TEST,
        S_DONE
    } t_state;

endpackage

// ----- rtl/glbp_box_store.sv -----
// ---------------------------------------------------------------------------
// glbp_box_store: occupied rectangle memory
// One write port, one registered read port, 64 bits per entry.
// ---------------------------------------------------------------------------
module glbp_box_store (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [glbp_pkg::IDX_W-1:0] i_waddr,
    input  logic [63:0]               i_wdata,
    input  logic [glbp_pkg::IDX_W-1:0] i_raddr,
    output logic [63:0]               o_rdata
);
    import glbp_pkg::*;

    logic [63:0] mem [MAX_BOXES];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- rtl/greedy_label_box_placer.sv -----
// ---------------------------------------------------------------------------
// greedy_label_box_placer: greedy six-position point label placement
// Keeps a store of occupied boxes and places labels at the first free spot.
// ---------------------------------------------------------------------------
// channel   dir  handshake              payload
// request   in   i_valid / o_ready      i_req_type .. i_rsv_bottom
// result    out  o_valid / i_ready      o_status .. o_placed_count
// config    in   i_cfg_we               i_cfg_index, i_cfg_data
//
// Reserve and clear go straight to the result. A place item first sets up the
// first candidate, then per tried position computes the candidate and, for
// each stored box, reads it and then compares it on the one shared overlap
// comparator.
// Reset clears counts and control; store contents need no clearing.
// The request side is not ready until the result has been transferred.
// ---------------------------------------------------------------------------
module greedy_label_box_placer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_point_x,
    input  logic [11:0] i_point_y,
    input  logic [11:0] i_text_w,
    input  logic [11:0] i_text_h,
    input  logic [11:0] i_line_h,
    input  logic signed [15:0] i_rsv_left,
    input  logic signed [15:0] i_rsv_top,
    input  logic signed [15:0] i_rsv_right,
    input  logic signed [15:0] i_rsv_bottom,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [2:0]  o_position_used,
    output logic signed [15:0] o_label_x,
    output logic signed [15:0] o_label_y,
    output logic signed [15:0] o_out_left,
    output logic signed [15:0] o_out_top,
    output logic signed [15:0] o_out_right,
    output logic signed [15:0] o_out_bottom,
    output logic [15:0] o_placed_count,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import glbp_pkg::*;

    // configuration
    logic [12:0] r_img_w, r_img_h;
    logic [7:0]  r_font;
    logic signed [8:0] r_rad, r_outl, r_pad;
    logic        r_avoid;
    logic [15:0] r_maxlab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 13'd1024; r_img_h <= 13'd1024; r_font <= 8'd12;
            r_rad <= 9'sd2; r_outl <= 9'sd1; r_pad <= 9'sd2;
            r_avoid <= 1'b1; r_maxlab <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMG_W:   r_img_w  <= i_cfg_data[12:0];
                CFG_IMG_H:   r_img_h  <= i_cfg_data[12:0];
                CFG_FONT:    r_font   <= i_cfg_data[7:0];
                CFG_RADIUS:  r_rad    <= i_cfg_data[8:0];
                CFG_OUTLINE: r_outl   <= i_cfg_data[8:0];
                CFG_PAD:     r_pad    <= i_cfg_data[8:0];
                CFG_AVOID:   r_avoid  <= i_cfg_data[0];
                CFG_MAXLAB:  r_maxlab <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_box_cnt;
    logic [15:0] r_lab_cnt;
    logic [IDX_W-1:0] r_idx;
    logic [2:0] r_pos;

    // item registers
    t_coord r_px, r_py, r_tw, r_th, r_rad_c, r_gap;
    t_rect  r_cand;
    t_coord r_cx, r_cy;
    logic   r_in_img;

    // result registers
    logic [2:0] r_status, r_posu;
    t_coord r_lx, r_ly;
    t_rect  r_ob;

    // store
    logic        s_we;
    logic [63:0] s_rdata;
    t_rect       s_box;
    logic [63:0] s_wdata;

    // candidate origin for position r_pos
    t_coord c_rg, c_cx, c_cy, c_l, c_t, c_r, c_b, c_o, c_mr, c_mb;
    t_rect  c_cand;
    always_comb begin
        c_rg = r_rad_c + r_gap;
        c_o  = t_coord'(r_outl);
        case (r_pos)
            3'd0: begin c_cx = r_px + c_rg; c_cy = r_py - (r_th >>> 1); end
            3'd1: begin c_cx = r_px - c_rg - r_tw; c_cy = r_py - (r_th >>> 1); end
            3'd2: begin c_cx = r_px - (r_tw >>> 1); c_cy = r_py - c_rg - r_th; end
            3'd3: begin c_cx = r_px - (r_tw >>> 1); c_cy = r_py + c_rg; end
            3'd4: begin c_cx = r_px + c_rg; c_cy = r_py - c_rg - r_th; end
            default: begin c_cx = r_px + c_rg; c_cy = r_py + c_rg; end
        endcase
        // marker right and bottom edges, exclusive
        c_mr = r_px + r_rad_c + t_coord'(1);
        c_mb = r_py + r_rad_c + t_coord'(1);
        c_l = ((r_px - r_rad_c) < c_cx) ? (r_px - r_rad_c) : c_cx;
        c_t = ((r_py - r_rad_c) < c_cy) ? (r_py - r_rad_c) : c_cy;
        c_r = (c_mr > (c_cx + r_tw)) ? c_mr : (c_cx + r_tw);
        c_b = (c_mb > (c_cy + r_th)) ? c_mb : (c_cy + r_th);
        c_cand.l = c_l - c_o;
        c_cand.t = c_t - c_o;
        c_cand.r = c_r + c_o;
        c_cand.b = c_b + c_o;
    end

    // shared overlap comparator against the box read from the store
    t_coord p;
    logic   hit;
    always_comb begin
        p = t_coord'(r_pad);
        s_box.l = t_coord'($signed(s_rdata[63:48]));
        s_box.t = t_coord'($signed(s_rdata[47:32]));
        s_box.r = t_coord'($signed(s_rdata[31:16]));
        s_box.b = t_coord'($signed(s_rdata[15:0]));
        hit = (r_cand.l < s_box.r + p) && (r_cand.r + p > s_box.l) &&
              (r_cand.t < s_box.b + p) && (r_cand.b + p > s_box.t);
    end

    // input decode
    logic [11:0] d_tw, d_th;
    logic signed [8:0] d_rad;
    logic signed [10:0] d_gap;
    always_comb begin
        d_tw  = (i_text_w == 12'd0) ? 12'd1 : i_text_w;
        d_th  = (i_text_h > i_line_h) ? i_text_h : i_line_h;
        if ({4'd0, r_font} > d_th) d_th = {4'd0, r_font};
        d_rad = (r_rad < 9'sd1) ? 9'sd1 : r_rad;
        d_gap = 11'(d_rad) + 11'(r_outl) + 11'sd2;
        if (d_gap < 11'sd3) d_gap = 11'sd3;
    end

    // r_pos is one ahead of the candidate held in r_cand
    logic full, last_pos, limit;
    assign full     = (r_box_cnt == CNT_W'(MAX_BOXES));
    assign last_pos = (r_pos == NUM_POS);
    assign limit    = (r_maxlab != 16'd0) && (r_lab_cnt >= r_maxlab);
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_DONE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                n_state = (i_req_type == REQ_PLACE && !limit) ? S_LOAD : S_DONE;
            end
            S_LOAD: n_state = S_CAND;
            S_CAND: begin
                if (!r_in_img) n_state = last_pos ? S_DONE : S_CAND;
                else if (r_avoid && r_box_cnt != '0) n_state = S_READ;
                else n_state = S_DONE;
            end
            S_READ: n_state = S_TEST;
            S_TEST: begin
                if (hit) n_state = last_pos ? S_DONE : S_CAND;
                else if (CNT_W'(r_idx) + 1'b1 == r_box_cnt) n_state = S_DONE;
                else n_state = S_READ;
            end
            S_DONE: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // store write on commit of reserve or placement
    logic commit_rsv, commit_place, accept;
    assign accept       = (r_state == S_IDLE) && i_valid;
    assign commit_rsv   = accept && i_req_type == REQ_RESERVE && !full;
    assign commit_place = ((r_state == S_CAND && r_in_img && !(r_avoid && r_box_cnt != '0)) ||
                          (r_state == S_TEST && !hit &&
                           CNT_W'(r_idx) + 1'b1 == r_box_cnt)) && !full;
    assign s_we = commit_rsv || commit_place;
    always_comb begin
        if (commit_rsv) s_wdata = {i_rsv_left, i_rsv_top, i_rsv_right, i_rsv_bottom};
        else s_wdata = {r_cand.l[15:0], r_cand.t[15:0], r_cand.r[15:0], r_cand.b[15:0]};
    end

    glbp_box_store u_store (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(r_box_cnt[IDX_W-1:0]),
        .i_wdata(s_wdata),
        .i_raddr(r_idx),
        .o_rdata(s_rdata)
    );

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_box_cnt <= '0;
            r_lab_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (s_we) r_box_cnt <= r_box_cnt + 1'b1;
            if (commit_place && r_lab_cnt != 16'hFFFF) r_lab_cnt <= r_lab_cnt + 1'b1;
            if (accept && i_req_type != REQ_RESERVE && i_req_type != REQ_PLACE) begin
                r_box_cnt <= '0;
                r_lab_cnt <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px    <= t_coord'({1'b0, i_point_x});
            r_py    <= t_coord'({1'b0, i_point_y});
            r_tw    <= t_coord'({1'b0, d_tw});
            r_th    <= t_coord'({1'b0, d_th});
            r_rad_c <= t_coord'(d_rad);
            r_gap   <= t_coord'(d_gap);
            r_pos   <= 3'd0;
            r_idx   <= '0;
            r_in_img <= 1'b0;
            r_posu  <= 3'd0;
            r_lx    <= '0;
            r_ly    <= '0;
            if (i_req_type == REQ_RESERVE) begin
                r_status <= full ? ST_FULL : ST_RESERVE;
                if (full) r_ob <= '0;
                else r_ob <= {t_coord'(i_rsv_left), t_coord'(i_rsv_top),
                              t_coord'(i_rsv_right), t_coord'(i_rsv_bottom)};
            end else if (i_req_type == REQ_PLACE) begin
                r_status <= limit ? ST_LIMIT : ST_NOPOS;
                r_ob     <= '0;
            end else begin
                r_status <= ST_CLEARED;
                r_ob     <= '0;
            end
        end
        // latch the candidate box for the current position, then advance
        if (r_state == S_LOAD ||
            ((r_state == S_CAND || r_state == S_TEST) && n_state == S_CAND)) begin
            r_cand   <= c_cand;
            r_cx     <= c_cx;
            r_cy     <= c_cy;
            r_in_img <= !(c_cand.l < 0 || c_cand.t < 0 ||
                          c_cand.r > t_coord'({1'b0, r_img_w}) ||
                          c_cand.b > t_coord'({1'b0, r_img_h}));
            r_idx    <= '0;
            r_pos    <= r_pos + 3'd1;
        end
        if (r_state == S_TEST && !hit) r_idx <= r_idx + 1'b1;
        if (r_state == S_CAND || r_state == S_TEST) begin
            if ((r_state == S_CAND && r_in_img && !(r_avoid && r_box_cnt != '0)) ||
                (r_state == S_TEST && !hit && CNT_W'(r_idx) + 1'b1 == r_box_cnt)) begin
                if (full) r_status <= ST_FULL;
                else begin
                    r_status <= ST_PLACED;
                    r_posu   <= r_pos - 3'd1;
                    r_lx     <= r_cx;
                    r_ly     <= r_cy;
                    r_ob     <= r_cand;
                end
            end
        end
    end

    assign o_status        = r_status;
    assign o_position_used = r_posu;
    assign o_label_x       = r_lx[15:0];
    assign o_label_y       = r_ly[15:0];
    assign o_out_left      = r_ob.l[15:0];
    assign o_out_top       = r_ob.t[15:0];
    assign o_out_right     = r_ob.r[15:0];
    assign o_out_bottom    = r_ob.b[15:0];
    assign o_placed_count  = r_lab_cnt;

endmodule

// ----- tb/greedy_label_box_placer_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// greedy_label_box_placer_test: self-checking bench for the label placer
// A queue-fed driver sends reserve, place and clear requests with random
// gaps. The monitor applies random back-pressure and checks every result
// field against an in-bench model of the box store and placement search.
// ---------------------------------------------------------------------------
module greedy_label_box_placer_test;
    import glbp_pkg::*;

    localparam logic [1:0] REQ_CLEAR     = 2'd2;
    localparam logic [1:0] REQ_CLEAR_ALT = 2'd3;
    localparam int         MAX_MISMATCH_SHOWN = 10;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [11:0]        px;
        logic [11:0]        py;
        logic [11:0]        tw;
        logic [11:0]        th;
        logic [11:0]        lh;
        logic signed [15:0] rl;
        logic signed [15:0] rt;
        logic signed [15:0] rr;
        logic signed [15:0] rb;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  pos;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] bl;
        logic [15:0] bt;
        logic [15:0] br;
        logic [15:0] bb;
        logic [15:0] count;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [11:0] i_point_x = '0, i_point_y = '0, i_text_w = '0, i_text_h = '0;
    logic [11:0] i_line_h = '0;
    logic signed [15:0] i_rsv_left = '0, i_rsv_top = '0, i_rsv_right = '0;
    logic signed [15:0] i_rsv_bottom = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status, o_position_used;
    logic signed [15:0] o_label_x, o_label_y, o_out_left, o_out_top;
    logic signed [15:0] o_out_right, o_out_bottom;
    logic [15:0] o_placed_count;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    greedy_label_box_placer i_dut (.*);

    always #4 i_clk = ~i_clk;

    // model state and shadow configuration
    longint    store_l[MAX_BOXES], store_t[MAX_BOXES];
    longint    store_r[MAX_BOXES], store_b[MAX_BOXES];
    int        boxes_held = 0;
    int        labels_placed = 0;
    longint    img_w = 1024, img_h = 1024, font_min = 12;
    longint    radius_cfg = 2, outline_cfg = 1, pad_cfg = 2;
    bit        avoid_on = 1'b1;
    longint    label_limit = 0;

    t_request  pending_requests[$];
    t_outcome  expected_outcomes[$];
    t_request  cur_req;
    int        send_wait = 0, recv_wait = 0;
    bit        steady = 1'b0;
    int        mismatches = 0;
    int        n_results = 0, n_placed = 0, n_full = 0, n_limit = 0, n_nopos = 0;

    function automatic longint imax(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint imin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    // append to the tail of the stimulus and expectation queues
    function automatic void enqueue_request(t_request q);
        pending_requests = {pending_requests, q};
    endfunction

    function automatic void enqueue_outcome(t_outcome o);
        expected_outcomes = {expected_outcomes, o};
    endfunction

    function automatic bit box_collides(longint l, longint t, longint r, longint b);
        for (int i = 0; i < boxes_held; i++)
            if (l < store_r[i] + pad_cfg && r + pad_cfg > store_l[i] &&
                t < store_b[i] + pad_cfg && b + pad_cfg > store_t[i])
                return 1'b1;
        return 1'b0;
    endfunction

    // expected answer to one request; updates the model store and counts
    function automatic t_outcome place_or_reserve(t_request q);
        t_outcome o;
        longint px, py, tw, th, rad, gap, hh, cx, cy, l, t, r, b;
        bit found;
        o = '0;
        o.status = ST_NOPOS;
        if (q.req_type == REQ_RESERVE) begin
            if (boxes_held >= MAX_BOXES) begin
                o.status = ST_FULL;
            end else begin
                store_l[boxes_held] = q.rl;
                store_t[boxes_held] = q.rt;
                store_r[boxes_held] = q.rr;
                store_b[boxes_held] = q.rb;
                boxes_held++;
                o.status = ST_RESERVE;
                o.bl = q.rl; o.bt = q.rt; o.br = q.rr; o.bb = q.rb;
            end
        end else if (q.req_type == REQ_PLACE) begin
            if (label_limit != 0 && labels_placed >= label_limit) begin
                o.status = ST_LIMIT;
            end else begin
                px = q.px; py = q.py;
                tw = imax(1, q.tw);
                th = imax(font_min, imax(q.th, q.lh));
                rad = imax(1, radius_cfg);
                gap = imax(3, rad + outline_cfg + 2);
                hh = th / 2;
                found = 1'b0;
                for (int k = 0; k < 6 && !found; k++) begin
                    case (k)
                        0: begin cx = px + rad + gap;      cy = py - hh; end
                        1: begin cx = px - rad - gap - tw; cy = py - hh; end
                        2: begin cx = px - tw / 2;         cy = py - rad - gap - th; end
                        3: begin cx = px - tw / 2;         cy = py + rad + gap; end
                        4: begin cx = px + rad + gap;      cy = py - rad - gap - th; end
                        default: begin cx = px + rad + gap; cy = py + rad + gap; end
                    endcase
                    l = imin(px - rad, cx) - outline_cfg;
                    t = imin(py - rad, cy) - outline_cfg;
                    r = imax(px + rad + 1, cx + tw) + outline_cfg;
                    b = imax(py + rad + 1, cy + th) + outline_cfg;
                    if (!(l < 0 || t < 0 || r > img_w || b > img_h) &&
                        !(avoid_on && box_collides(l, t, r, b))) begin
                        found = 1'b1;
                        if (boxes_held >= MAX_BOXES) begin
                            o.status = ST_FULL;
                        end else begin
                            store_l[boxes_held] = l; store_t[boxes_held] = t;
                            store_r[boxes_held] = r; store_b[boxes_held] = b;
                            boxes_held++;
                            if (labels_placed < 65535) labels_placed++;
                            o.status = ST_PLACED;
                            o.pos = k[2:0];
                            o.lx = cx[15:0]; o.ly = cy[15:0];
                            o.bl = l[15:0]; o.bt = t[15:0];
                            o.br = r[15:0]; o.bb = b[15:0];
                        end
                    end
                end
            end
        end else begin
            boxes_held = 0;
            labels_placed = 0;
            o.status = ST_CLEARED;
        end
        o.count = labels_placed[15:0];
        return o;
    endfunction

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !o_ready)) begin
            if (i_valid)
                enqueue_outcome(place_or_reserve(cur_req));
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
                i_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                cur_req = pending_requests.pop_front();
                i_req_type <= cur_req.req_type;
                i_point_x <= cur_req.px;
                i_point_y <= cur_req.py;
                i_text_w <= cur_req.tw;
                i_text_h <= cur_req.th;
                i_line_h <= cur_req.lh;
                i_rsv_left <= cur_req.rl;
                i_rsv_top <= cur_req.rt;
                i_rsv_right <= cur_req.rr;
                i_rsv_bottom <= cur_req.rb;
                i_valid <= 1'b1;
                send_wait <= draw_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_status, o_position_used, o_label_x, o_label_y, o_out_left,
                   o_out_top, o_out_right, o_out_bottom, o_placed_count};
            n_results++;
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_MISMATCH_SHOWN)
                    $display("unexpected result transfer: %h", got);
            end else begin
                want = expected_outcomes.pop_front();
                if (want.status == ST_PLACED) n_placed++;
                if (want.status == ST_FULL) n_full++;
                if (want.status == ST_LIMIT) n_limit++;
                if (want.status == ST_NOPOS) n_nopos++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_MISMATCH_SHOWN) begin
                        $display("mismatch #%0d: exp st=%0d pos=%0d lx=%0d ly=%0d %s",
                                 n_results, want.status, want.pos,
                                 $signed(want.lx), $signed(want.ly), "");
                        $display("    exp box=%0d,%0d,%0d,%0d cnt=%0d",
                                 $signed(want.bl), $signed(want.bt),
                                 $signed(want.br), $signed(want.bb), want.count);
                        $display("    got st=%0d pos=%0d lx=%0d ly=%0d",
                                 got.status, got.pos, $signed(got.lx), $signed(got.ly));
                        $display("    got box=%0d,%0d,%0d,%0d cnt=%0d",
                                 $signed(got.bl), $signed(got.bt),
                                 $signed(got.br), $signed(got.bb), got.count);
                    end
                end
            end
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            i_ready <= 1'b0;
        end else if (o_valid && i_ready) begin
            recv_wait <= draw_gap();
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // register write, mirrored into the model; only called while idle
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_IMG_W:   img_w = val[12:0];
            CFG_IMG_H:   img_h = val[12:0];
            CFG_FONT:    font_min = val[7:0];
            CFG_RADIUS:  radius_cfg = $signed(val[8:0]);
            CFG_OUTLINE: outline_cfg = $signed(val[8:0]);
            CFG_PAD:     pad_cfg = $signed(val[8:0]);
            CFG_AVOID:   avoid_on = val[0];
            default:     label_limit = val;
        endcase
    endtask

    task automatic write_all(input int w, input int h, input int f, input int rad,
                             input int outl, input int pad, input int av, input int ml);
        write_reg(CFG_IMG_W, w[15:0]);
        write_reg(CFG_IMG_H, h[15:0]);
        write_reg(CFG_FONT, f[15:0]);
        write_reg(CFG_RADIUS, rad[15:0]);
        write_reg(CFG_OUTLINE, outl[15:0]);
        write_reg(CFG_PAD, pad[15:0]);
        write_reg(CFG_AVOID, av[15:0]);
        write_reg(CFG_MAXLAB, ml[15:0]);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_requests.size() != 0 || i_valid || expected_outcomes.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_request make_req(logic [1:0] rt, int px, int py, int tw,
                                          int th, int lh);
        t_request q;
        q = '0;
        q.req_type = rt;
        q.px = px[11:0]; q.py = py[11:0];
        q.tw = tw[11:0]; q.th = th[11:0]; q.lh = lh[11:0];
        return q;
    endfunction

    function automatic t_request make_box(int l, int t, int r, int b);
        t_request q;
        q = '0;
        q.req_type = REQ_RESERVE;
        q.rl = l[15:0]; q.rt = t[15:0]; q.rr = r[15:0]; q.rb = b[15:0];
        return q;
    endfunction

    // random request: mostly well-formed places and reserves, some noise
    function automatic t_request random_req();
        t_request q;
        logic [159:0] raw;
        int pick, lo, to;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        q = raw[$bits(t_request)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
            q.req_type = REQ_PLACE;
            if ($urandom_range(0, 9) != 0) begin
                q.px = 12'($urandom_range(0, (img_w > 1) ? img_w - 1 : 0));
                q.py = 12'($urandom_range(0, (img_h > 1) ? img_h - 1 : 0));
                q.tw = 12'($urandom_range(0, 80));
                q.th = 12'($urandom_range(0, 30));
                q.lh = 12'($urandom_range(0, 30));
            end
        end else if (pick < 88) begin
            q.req_type = REQ_RESERVE;
            if ($urandom_range(0, 7) != 0) begin
                lo = $urandom_range(0, 1100) - 50;
                to = $urandom_range(0, 1100) - 50;
                q.rl = lo[15:0]; q.rt = to[15:0];
                q.rr = 16'(lo + $urandom_range(0, 120) - 10);
                q.rb = 16'(to + $urandom_range(0, 120) - 10);
            end
        end else if (pick < 94) begin
            q.req_type = REQ_CLEAR;
        end else if (pick < 97) begin
            q.req_type = REQ_CLEAR_ALT;
        end else begin
            q.req_type = REQ_PLACE;
        end
        return q;
    endfunction

    function automatic int pick_signed_cfg(int typical);
        case ($urandom_range(0, 5))
            0: return -255;
            1: return 255;
            2: return $urandom_range(0, 510) - 255;
            default: return typical;
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings
        enqueue_request(make_req(REQ_PLACE, 500, 500, 40, 10, 14));
        enqueue_request(make_req(REQ_PLACE, 500, 500, 40, 10, 14));
        enqueue_request(make_req(REQ_PLACE, 500, 500, 40, 10, 14));
        enqueue_request(make_req(REQ_PLACE, 0, 0, 10, 0, 0));
        enqueue_request(make_req(REQ_PLACE, 4095, 4095, 4095, 4095, 4095));
        enqueue_request(make_req(REQ_PLACE, 200, 200, 0, 0, 0));
        enqueue_request(make_box(-32768, -32768, 32767, 32767));
        enqueue_request(make_req(REQ_PLACE, 300, 300, 20, 8, 8));
        enqueue_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
        enqueue_request(make_box(600, 590, 700, 620));
        enqueue_request(make_req(REQ_PLACE, 600, 600, 30, 12, 12));
        enqueue_request(make_req(REQ_CLEAR_ALT, 4095, 4095, 4095, 4095, 4095));
        enqueue_request(make_req(REQ_PLACE, 1010, 1010, 30, 12, 12));
        drain();
        // directed: label limit of one, no overlap test
        write_all(4096, 4096, 255, -255, -255, -255, 0, 1);
        enqueue_request(make_req(REQ_PLACE, 2000, 2000, 100, 0, 0));
        enqueue_request(make_req(REQ_PLACE, 2000, 2000, 100, 0, 0));
        enqueue_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
        enqueue_request(make_req(REQ_PLACE, 2000, 2000, 100, 0, 0));
        drain();
        // directed: zero-size image, every position out of bounds
        write_all(0, 0, 0, 255, 255, 255, 1, 65535);
        enqueue_request(make_req(REQ_PLACE, 0, 0, 0, 0, 0));
        enqueue_request(make_req(REQ_PLACE, 4095, 4095, 1, 1, 1));
        drain();
        // directed: large radius and outline
        write_all(4096, 4096, 0, 255, 255, 2, 1, 0);
        enqueue_request(make_req(REQ_PLACE, 2048, 2048, 50, 20, 5));
        enqueue_request(make_req(REQ_PLACE, 2048, 2048, 50, 20, 5));
        drain();

        // random phases under varied settings
        for (int ph = 0; ph < 6; ph++) begin
            steady = (ph == 2);
            write_all(($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(256, 1500),
                      ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(256, 1500),
                      ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
                                                  : $urandom_range(0, 20),
                      pick_signed_cfg($urandom_range(0, 6)),
                      pick_signed_cfg($urandom_range(0, 3)),
                      pick_signed_cfg($urandom_range(0, 4)),
                      int'((ph % 3) != 1),
                      ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0);
            enqueue_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
            repeat (34) enqueue_request(random_req());
            drain();
        end
        steady = 1'b0;

        // store-full phase: fill with boxes out of the image, then overflow
        write_all(4096, 4096, 12, 2, 1, 2, 1, 0);
        enqueue_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
        repeat (MAX_BOXES - 1) begin
            int l, t;
            l = -$urandom_range(200, 30000);
            t = $urandom_range(0, 65535) - 32768;
            enqueue_request(make_box(l, t, l + $urandom_range(0, 150),
                                     t + $urandom_range(0, 150)));
        end
        enqueue_request(make_req(REQ_PLACE, 1000, 1000, 30, 10, 10));
        enqueue_request(make_box(1, 2, 3, 4));
        enqueue_request(make_req(REQ_PLACE, 2000, 2000, 30, 10, 10));
        enqueue_request(make_req(REQ_PLACE, 0, 0, 4095, 10, 10));
        drain();
        write_reg(CFG_AVOID, 16'd0);
        enqueue_request(make_req(REQ_PLACE, 1000, 1000, 30, 10, 10));
        enqueue_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
        enqueue_request(make_req(REQ_PLACE, 1000, 1000, 30, 10, 10));
        drain();

        repeat (20) @(posedge i_clk);
        if (expected_outcomes.size() != 0) begin
            mismatches += expected_outcomes.size();
            $display("%0d expected results never arrived", expected_outcomes.size());
        end
        $display("%0d results checked: %0d placed, %0d no position, %0d limit, %0d store full",
                 n_results, n_placed, n_nopos, n_limit, n_full);
        $display("%0d mismatches over reset, extreme and random register settings",
                 mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial begin
        #100_000_000;
        $display("timeout with %0d results outstanding", expected_outcomes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
